// ----- src/mf3_pkg.sv -----
// Shared constants and types for the 3x3 median filter.
package mf3_pkg;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 11;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIZE   = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIN_SIZE   = 9;
    localparam int CENTER_IDX = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t win_t [WIN_SIZE];

    typedef struct packed {
        logic             produce;
        logic             border;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pix_t             center;
    } meta_t;

endpackage

// ----- src/median_filter_3x3.sv -----
// Streaming 3x3 median filter with a combined two-row line buffer and a pipelined sort network.
// One word is accepted per clock while the output side keeps up; each accepted pixel yields
// one result word on the output after passing stages s1 to s4 and the output register. The pace
// is set by the single line-buffer memory, read once and written once per pixel, and by the
// three-stage median network behind it.
// Reset clears the counters, the window and all pipeline valid flags and loads a 640x480 frame.
// The line buffer is not cleared; entries are only used once written in the current frame.
module median_filter_3x3 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mf3_pkg::PIX_W-1:0]        s_pixel_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_out_valid,
    output logic [mf3_pkg::PIX_W-1:0]        m_pixel_out,
    output logic [mf3_pkg::ROW_W-1:0]        m_out_row,
    output logic [mf3_pkg::COL_W-1:0]        m_out_col,
    output logic                             m_is_border,
    input  logic                             cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mf3_pkg::SIZE_W-1:0]       cfg_wdata
);

    localparam int PW = mf3_pkg::PIX_W;
    localparam int SW = mf3_pkg::SIZE_W;
    localparam int CW = mf3_pkg::COL_W;
    localparam int RW = mf3_pkg::ROW_W;

    function automatic mf3_pkg::win_t order_pair(input mf3_pkg::win_t p, input int a,
                                                 input int b);
        mf3_pkg::win_t q;
        q = p;
        if (p[a] > p[b]) begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

    function automatic mf3_pkg::win_t net_part1(input mf3_pkg::win_t p);
        mf3_pkg::win_t q;
        q = p;
        q = order_pair(q, 1, 2);
        q = order_pair(q, 4, 5);
        q = order_pair(q, 7, 8);
        q = order_pair(q, 0, 1);
        q = order_pair(q, 3, 4);
        q = order_pair(q, 6, 7);
        q = order_pair(q, 1, 2);
        q = order_pair(q, 4, 5);
        q = order_pair(q, 7, 8);
        return q;
    endfunction

    function automatic mf3_pkg::win_t net_part2(input mf3_pkg::win_t p);
        mf3_pkg::win_t q;
        q = p;
        q = order_pair(q, 0, 3);
        q = order_pair(q, 5, 8);
        q = order_pair(q, 4, 7);
        q = order_pair(q, 3, 6);
        q = order_pair(q, 1, 4);
        q = order_pair(q, 2, 5);
        q = order_pair(q, 4, 7);
        return q;
    endfunction

    function automatic mf3_pkg::win_t net_part3(input mf3_pkg::win_t p);
        mf3_pkg::win_t q;
        q = p;
        q = order_pair(q, 4, 2);
        q = order_pair(q, 6, 4);
        q = order_pair(q, 4, 2);
        return q;
    endfunction

    logic [SW-1:0] width_reg, height_reg;
    logic [SW-1:0] width_eff, height_eff;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] col_inc, row_inc;

    logic [2*PW-1:0] line_mem [mf3_pkg::MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;

    logic pipe_en, accept;

    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    mf3_pkg::pix_t  s1_px_reg;
    logic [CW-1:0]  s1_col_reg;
    mf3_pkg::meta_t s1_meta_reg, s1_meta_next, s2_meta_reg, s3_meta_reg, s3_meta_next;
    mf3_pkg::meta_t s4_meta_reg;
    mf3_pkg::win_t  win_reg, win_next, s3_win_reg, s4_win_reg, final_win;

    logic           m_valid_reg, m_out_valid_reg, m_is_border_reg;
    mf3_pkg::pix_t  m_pixel_reg;
    logic [RW-1:0]  m_row_reg;
    logic [CW-1:0]  m_col_reg;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;
    assign accept  = s_valid && pipe_en;

    always_comb begin
        width_eff = width_reg;
        if (width_reg < SW'(mf3_pkg::MIN_SIZE)) begin
            width_eff = SW'(mf3_pkg::MIN_SIZE);
        end else if (width_reg > SW'(mf3_pkg::MAX_WIDTH)) begin
            width_eff = SW'(mf3_pkg::MAX_WIDTH);
        end
        height_eff = height_reg;
        if (height_reg < SW'(mf3_pkg::MIN_SIZE)) begin
            height_eff = SW'(mf3_pkg::MIN_SIZE);
        end else if (height_reg > SW'(mf3_pkg::MAX_HEIGHT)) begin
            height_eff = SW'(mf3_pkg::MAX_HEIGHT);
        end
    end

    always_comb begin
        col_inc  = SW'(col_reg) + SW'(1);
        row_inc  = SW'(row_reg) + SW'(1);
        col_next = col_inc[CW-1:0];
        row_next = row_reg;
        if (col_inc >= width_eff) begin
            col_next = '0;
            row_next = row_inc[RW-1:0];
            if (row_inc >= height_eff) begin
                row_next = '0;
            end
        end
    end

    always_comb begin
        s1_meta_next         = '0;
        s1_meta_next.produce = (row_reg != '0) && (col_reg != '0);
        if (s1_meta_next.produce) begin
            s1_meta_next.row    = row_reg - RW'(1);
            s1_meta_next.col    = col_reg - CW'(1);
            s1_meta_next.border = (s1_meta_next.row == '0) || (s1_meta_next.col == '0);
        end
    end

    always_comb begin
        s3_meta_next        = s2_meta_reg;
        s3_meta_next.center = win_reg[mf3_pkg::CENTER_IDX];
    end

    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_reg[PW-1:0];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_reg[2*PW-1:PW];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_px_reg;
    end

    assign final_win = net_part3(s4_win_reg);

    // Configuration and frame counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mf3_pkg::RESET_WIDTH;
            height_reg <= mf3_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                mf3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line buffer: each entry holds the previous row above the older row.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[col_reg];
        end
        if (pipe_en && s1_valid_reg) begin
            line_mem[s1_col_reg] <= {s1_px_reg, rd_reg[2*PW-1:PW]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            win_reg      <= '{default: '0};
        end else if (pipe_en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_px_reg          <= s_pixel_in;
            s1_col_reg         <= col_reg;
            s1_meta_reg        <= s1_meta_next;
            s2_meta_reg        <= s1_meta_reg;
            s3_meta_reg        <= s3_meta_next;
            s3_win_reg         <= net_part1(win_reg);
            s4_meta_reg        <= s3_meta_reg;
            s4_win_reg         <= net_part2(s3_win_reg);
            m_out_valid_reg    <= s4_meta_reg.produce;
            m_is_border_reg    <= s4_meta_reg.border;
            m_row_reg          <= s4_meta_reg.row;
            m_col_reg          <= s4_meta_reg.col;
            if (!s4_meta_reg.produce) begin
                m_pixel_reg <= '0;
            end else if (s4_meta_reg.border) begin
                m_pixel_reg <= s4_meta_reg.center;
            end else begin
                m_pixel_reg <= final_win[mf3_pkg::CENTER_IDX];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_valid = m_out_valid_reg;
    assign m_pixel_out = m_pixel_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_is_border = m_is_border_reg;

    a_border_on_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_border |-> m_out_valid && (m_out_row == '0 || m_out_col == '0))
        else $error("Border word away from the top row and left column.");

    a_empty_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_valid |-> m_pixel_out == '0 && !m_is_border && m_out_row == '0)
        else $error("Word without an output pixel carries nonzero fields.");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(col_reg) < width_eff && SW'(row_reg) < height_eff)
        else $error("Frame counter beyond the effective frame size.");

    a_col_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_we && col_inc < width_eff |=> col_reg == $past(col_reg) + CW'(1))
        else $error("Column counter did not advance on an accepted word.");

endmodule

// ----- sim/median_filter_3x3_test.sv -----
// Self-checking testbench for the streaming 3x3 median filter, with a predictor kept in a class.
module median_filter_3x3_test;

    timeunit 1ns;
    timeprecision 1ps;

    class median_tracker;

        typedef struct packed {
            logic                      produce;
            mf3_pkg::pix_t             pixel;
            logic [mf3_pkg::ROW_W-1:0] row;
            logic [mf3_pkg::COL_W-1:0] col;
            logic                      border;
        } pixel_word_t;

        logic [mf3_pkg::SIZE_W-1:0] width_reg;
        logic [mf3_pkg::SIZE_W-1:0] height_reg;
        mf3_pkg::pix_t              recent_row [mf3_pkg::MAX_WIDTH];
        mf3_pkg::pix_t              older_row [mf3_pkg::MAX_WIDTH];
        mf3_pkg::pix_t              window [mf3_pkg::WIN_SIZE];
        int unsigned                col_pos;
        int unsigned                row_pos;
        pixel_word_t                pending [$];
        int unsigned                errors;

        function new();
            width_reg  = mf3_pkg::RESET_WIDTH;
            height_reg = mf3_pkg::RESET_HEIGHT;
            foreach (recent_row[i]) begin
                recent_row[i] = '0;
                older_row[i]  = '0;
            end
            foreach (window[i]) window[i] = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function int unsigned effective_size(logic [mf3_pkg::SIZE_W-1:0] raw,
                                             int unsigned limit);
            if (raw < mf3_pkg::MIN_SIZE) return mf3_pkg::MIN_SIZE;
            if (raw > limit) return limit;
            return 32'(raw);
        endfunction

        function void set_register(logic [mf3_pkg::CFG_IDX_W-1:0] index,
                                   logic [mf3_pkg::SIZE_W-1:0] value);
            if (index == mf3_pkg::REG_IMAGE_WIDTH) width_reg = value;
            else height_reg = value;
            col_pos = 0;
            row_pos = 0;
        endfunction

        // The median is the value with at most four smaller entries and at least five
        // entries not above it.
        function mf3_pkg::pix_t window_median();
            int lower;
            int not_above;
            for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
                lower     = 0;
                not_above = 0;
                for (int j = 0; j < mf3_pkg::WIN_SIZE; j++) begin
                    if (window[j] < window[i]) lower++;
                    if (window[j] <= window[i]) not_above++;
                end
                if (lower <= 4 && not_above >= 5) return window[i];
            end
            return '0;
        endfunction

        function void take_pixel(mf3_pkg::pix_t pixel);
            int unsigned   w = effective_size(width_reg, mf3_pkg::MAX_WIDTH);
            int unsigned   h = effective_size(height_reg, mf3_pkg::MAX_HEIGHT);
            int unsigned   c = col_pos;
            int unsigned   r = row_pos;
            mf3_pkg::pix_t up_one;
            mf3_pkg::pix_t up_two;
            pixel_word_t   word;
            if (c >= w) c = 0;
            if (r >= h) r = 0;
            up_one = recent_row[c];
            up_two = older_row[c];
            for (int k = 0; k < 3; k++) begin
                window[k*3]     = window[k*3 + 1];
                window[k*3 + 1] = window[k*3 + 2];
            end
            window[2] = up_two;
            window[5] = up_one;
            window[8] = pixel;
            older_row[c]  = up_one;
            recent_row[c] = pixel;
            word = '0;
            if (r >= 1 && c >= 1) begin
                word.produce = 1'b1;
                word.row     = mf3_pkg::ROW_W'(r - 1);
                word.col     = mf3_pkg::COL_W'(c - 1);
                word.border  = (r == 1 || c == 1);
                word.pixel   = word.border ? window[mf3_pkg::CENTER_IDX] : window_median();
            end
            pending.push_back(word);
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void match_output(logic produce, mf3_pkg::pix_t pixel,
                                   logic [mf3_pkg::ROW_W-1:0] row,
                                   logic [mf3_pkg::COL_W-1:0] col, logic border);
            pixel_word_t want;
            if (pending.size() == 0) begin
                $display("%0t ns: result word with none expected (pixel %0d)", $time, pixel);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (produce !== want.produce) begin
                $display("%0t ns: out_valid expected %0d, got %0d", $time, want.produce, produce);
                errors++;
            end
            if (pixel !== want.pixel) begin
                $display("%0t ns: pixel_out expected %0d, got %0d", $time, want.pixel, pixel);
                errors++;
            end
            if (row !== want.row) begin
                $display("%0t ns: out_row expected %0d, got %0d", $time, want.row, row);
                errors++;
            end
            if (col !== want.col) begin
                $display("%0t ns: out_col expected %0d, got %0d", $time, want.col, col);
                errors++;
            end
            if (border !== want.border) begin
                $display("%0t ns: is_border expected %0d, got %0d", $time, want.border, border);
                errors++;
            end
        endfunction

    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    mf3_pkg::pix_t                 s_pixel_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_out_valid;
    mf3_pkg::pix_t                 m_pixel_out;
    logic [mf3_pkg::ROW_W-1:0]     m_out_row;
    logic [mf3_pkg::COL_W-1:0]     m_out_col;
    logic                          m_is_border;
    logic                          cfg_we = 1'b0;
    logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index = mf3_pkg::REG_IMAGE_WIDTH;
    logic [mf3_pkg::SIZE_W-1:0]    cfg_wdata = '0;

    median_tracker tracker = new();
    bit            calm = 1'b0;
    bit            hold_request = 1'b0;

    mf3_pkg::pix_t directed_pixels [25] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h00,
        8'hFF, 8'hFF, 8'h00, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60,
        8'h80, 8'h80, 8'h80, 8'h00, 8'hFF, 8'hC3, 8'h3C
    };

    median_filter_3x3 DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_valid (m_out_valid),
        .m_pixel_out (m_pixel_out),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_is_border (m_is_border),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 17);
    endfunction

    function automatic mf3_pkg::pix_t draw_pixel(mf3_pkg::pix_t base);
        int pick = $urandom_range(0, 99);
        if (pick < 60) return mf3_pkg::pix_t'($urandom);
        if (pick < 85) return base + mf3_pkg::pix_t'($urandom_range(0, 7));
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    function automatic logic [mf3_pkg::SIZE_W-1:0] pick_size(int typical_hi);
        int pick = $urandom_range(0, 19);
        if (pick == 0) return mf3_pkg::SIZE_W'($urandom_range(0, 2));
        if (pick == 1) return mf3_pkg::SIZE_W'($urandom_range(1025, 2047));
        if (pick == 2) return mf3_pkg::SIZE_W'(mf3_pkg::MAX_WIDTH);
        return mf3_pkg::SIZE_W'($urandom_range(mf3_pkg::MIN_SIZE, typical_hi));
    endfunction

    task automatic send_pixel(mf3_pkg::pix_t pixel);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= pixel;
        do @(posedge aclk); while (!s_ready);
        tracker.take_pixel(pixel);
    endtask

    task automatic run_pixels(int count, mf3_pkg::pix_t base);
        for (int i = 0; i < count; i++) send_pixel(draw_pixel(base));
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_frame(bit set_width, logic [mf3_pkg::SIZE_W-1:0] width_value,
                                 bit set_height, logic [mf3_pkg::SIZE_W-1:0] height_value);
        if (set_width) begin
            cfg_we    <= 1'b1;
            cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
            cfg_wdata <= width_value;
            @(posedge aclk);
            tracker.set_register(mf3_pkg::REG_IMAGE_WIDTH, width_value);
        end
        if (set_height) begin
            cfg_we    <= 1'b1;
            cfg_index <= mf3_pkg::REG_IMAGE_HEIGHT;
            cfg_wdata <= height_value;
            @(posedge aclk);
            tracker.set_register(mf3_pkg::REG_IMAGE_HEIGHT, height_value);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.match_output(m_out_valid, m_pixel_out, m_out_row, m_out_col, m_is_border);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !take_break();
            end
        end
    end

    initial begin
        #500_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int                         random_items;
        int                         count;
        int                         which;
        logic [mf3_pkg::SIZE_W-1:0] w;
        logic [mf3_pkg::SIZE_W-1:0] h;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The reset frame size keeps this stream on the top row.
        run_pixels(40, mf3_pkg::pix_t'($urandom));

        drain_results();
        program_frame(1'b1, mf3_pkg::SIZE_W'(3), 1'b1, mf3_pkg::SIZE_W'(3));
        foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
        s_valid <= 1'b0;

        // Oversized width clamps to the widest row, undersized height to three rows.
        drain_results();
        program_frame(1'b1, mf3_pkg::SIZE_W'(2047), 1'b1, mf3_pkg::SIZE_W'(0));
        run_pixels(30, mf3_pkg::pix_t'($urandom));

        // Undersized width clamps to three pixels; both sides run without a gap.
        drain_results();
        calm = 1'b1;
        program_frame(1'b1, mf3_pkg::SIZE_W'(1), 1'b1, mf3_pkg::SIZE_W'(2047));
        run_pixels(80, mf3_pkg::pix_t'($urandom));
        calm = 1'b0;

        // The result side stops for a long stretch while words keep coming in.
        drain_results();
        program_frame(1'b1, mf3_pkg::SIZE_W'(5), 1'b1, mf3_pkg::SIZE_W'(4));
        hold_request = 1'b1;
        run_pixels(100, mf3_pkg::pix_t'($urandom));

        random_items = 0;
        while (random_items < 130) begin
            drain_results();
            w     = pick_size(10);
            h     = pick_size(7);
            which = $urandom_range(0, 2);
            program_frame(which != 1, w, which != 0, h);
            count = $urandom_range(15, 60);
            run_pixels(count, mf3_pkg::pix_t'($urandom));
            random_items += count;
        end

        drain_results();
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
